// ===== rtl/core/four_point_polyline_interpolator_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Polyline interpolator assertion macros
// Shorthand for clocked implication checks, sampled on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef FOUR_POINT_POLYLINE_INTERPOLATOR_UNIT_MACROS_SVH
`define FOUR_POINT_POLYLINE_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define FPPI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("polyline interpolator check failed");

// next-cycle implication
`define FPPI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("polyline interpolator check failed");

`endif

// ===== rtl/core/fppi_pkg.sv =====
// ---------------------------------------------------------------------------
// Polyline interpolator package
// Widths, register codes, reset breakpoints and pipeline word types.
// ---------------------------------------------------------------------------
package fppi_pkg;

    localparam int FRAC_BITS = 8;
    localparam int X_W       = 17;
    localparam int Y_W       = 16;
    localparam int PT_W      = 8;
    localparam int NUM_PTS   = 4;
    localparam int IDX_W     = 3;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_X_POINT_0 = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_Y_POINT_0 = IDX_W'(4);

    localparam logic [NUM_PTS-1:0][PT_W-1:0] X_PT_RESET = {8'd100, 8'd66, 8'd33, 8'd0};
    localparam logic [NUM_PTS-1:0][PT_W-1:0] Y_PT_RESET = {8'd100, 8'd66, 8'd33, 8'd0};

    // offset into a segment, and compare width for x against scaled breakpoints
    localparam int DX_W = PT_W + FRAC_BITS;
    localparam int CW   = ((X_W > DX_W + 1) ? X_W : DX_W + 1) + 1;

    // divider: two quotient bits per stage
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = (DX_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int QP         = DIV_STEPS * DIV_STAGES;
    localparam int MW         = PT_W + QP;
    localparam int YW         = ((QP + 2) > (Y_W + 1)) ? (QP + 2) : (Y_W + 1);

    // select, multiply, divide stages, sum
    localparam int NUM_STAGES = DIV_STAGES + 3;

    typedef struct packed {
        logic [NUM_PTS-1:0][PT_W-1:0] x_pt;
        logic [NUM_PTS-1:0][PT_W-1:0] y_pt;
    } cfg_t;

    typedef struct packed {
        logic [DX_W-1:0]        dx;
        logic [PT_W-1:0]        dy_mag;
        logic                   neg;
        logic [PT_W-1:0]        w;
        logic signed [PT_W-1:0] base;
        logic                   ok;
    } seg_t;

    typedef struct packed {
        logic [MW-1:0]          mag;
        logic [PT_W-1:0]        w;
        logic signed [PT_W-1:0] base;
        logic                   neg;
        logic                   ok;
    } prod_t;

    typedef struct packed {
        logic [PT_W-1:0]        rem;
        logic [QP-1:0]          dq;
        logic [PT_W-1:0]        w;
        logic signed [PT_W-1:0] base;
        logic                   neg;
        logic                   ok;
    } div_t;

endpackage

// ===== rtl/core/fppi_front.sv =====
// ---------------------------------------------------------------------------
// Polyline interpolator front end
// Segment select and offset (stage 0), offset times rise (stage 1).
// ---------------------------------------------------------------------------
module fppi_front
    import fppi_pkg::*;
(
    input  logic                  clk,
    input  logic [1:0]            en,
    input  logic signed [X_W-1:0] x_in,
    input  cfg_t                  cfg,
    output prod_t                 prod
);

    logic signed [CW-1:0]  xs;
    logic signed [CW-1:0]  diff [NUM_PTS];
    logic [NUM_PTS-1:0]    ge;
    logic signed [PT_W:0]  dyf  [NUM_PTS-1];
    logic [PT_W:0]         dabs [NUM_PTS-1];
    logic [PT_W-1:0]       wd   [NUM_PTS-1];
    logic                  ok;
    logic                  interp;
    seg_t                  s0_next;
    seg_t                  s0_reg;
    prod_t                 s1_next;
    prod_t                 s1_reg;

    always_comb
    begin
        xs = CW'(x_in);
        for (int i = 0; i < NUM_PTS; i++)
        begin
            diff[i] = xs - $signed(CW'({cfg.x_pt[i], {FRAC_BITS{1'b0}}}));
            ge[i]   = !diff[i][CW-1];
        end
        for (int i = 0; i < NUM_PTS - 1; i++)
        begin
            dyf[i]  = $signed({cfg.y_pt[i+1][PT_W-1], cfg.y_pt[i+1]})
                    - $signed({cfg.y_pt[i][PT_W-1], cfg.y_pt[i]});
            dabs[i] = dyf[i][PT_W] ? (PT_W+1)'(-dyf[i]) : dyf[i];
            wd[i]   = cfg.x_pt[i+1] - cfg.x_pt[i];
        end
        ok = (cfg.x_pt[0] <= cfg.x_pt[1]) && (cfg.x_pt[1] <= cfg.x_pt[2])
          && (cfg.x_pt[2] <= cfg.x_pt[3]);
        interp = ok && ge[0] && !ge[3];

        s0_next.ok = ok;
        if (interp)
        begin
            priority if (ge[2])
            begin
                s0_next.dx     = diff[2][DX_W-1:0];
                s0_next.dy_mag = dabs[2][PT_W-1:0];
                s0_next.neg    = dyf[2][PT_W];
                s0_next.w      = wd[2];
                s0_next.base   = $signed(cfg.y_pt[2]);
            end
            else if (ge[1])
            begin
                s0_next.dx     = diff[1][DX_W-1:0];
                s0_next.dy_mag = dabs[1][PT_W-1:0];
                s0_next.neg    = dyf[1][PT_W];
                s0_next.w      = wd[1];
                s0_next.base   = $signed(cfg.y_pt[1]);
            end
            else
            begin
                s0_next.dx     = diff[0][DX_W-1:0];
                s0_next.dy_mag = dabs[0][PT_W-1:0];
                s0_next.neg    = dyf[0][PT_W];
                s0_next.w      = wd[0];
                s0_next.base   = $signed(cfg.y_pt[0]);
            end
        end
        else
        begin
            // clamp or bad curve: zero slope term, unit divisor
            s0_next.dx     = '0;
            s0_next.dy_mag = '0;
            s0_next.neg    = 1'b0;
            s0_next.w      = PT_W'(1);
            priority if (!ok)
                s0_next.base = '0;
            else if (!ge[0])
                s0_next.base = $signed(cfg.y_pt[0]);
            else
                s0_next.base = $signed(cfg.y_pt[NUM_PTS-1]);
        end
    end

    always_comb
    begin
        s1_next.mag  = MW'(s0_reg.dx * s0_reg.dy_mag);
        s1_next.w    = s0_reg.w;
        s1_next.base = s0_reg.base;
        s1_next.neg  = s0_reg.neg;
        s1_next.ok   = s0_reg.ok;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            s0_reg <= s0_next;
        if (en[1])
            s1_reg <= s1_next;
    end

    assign prod = s1_reg;

endmodule

// ===== rtl/core/fppi_div.sv =====
// ---------------------------------------------------------------------------
// Polyline interpolator divider
// Restoring divide of the product magnitude by the segment width.
// ---------------------------------------------------------------------------
module fppi_div
    import fppi_pkg::*;
(
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] en,
    input  prod_t                 prod,
    output div_t                  quot
);

    div_t div_next [DIV_STAGES];
    div_t div_reg  [DIV_STAGES];
    div_t div_init;

    function automatic div_t div_step(div_t d);
        div_t          r;
        logic [PT_W:0] t;
        r = d;
        t = {d.rem, d.dq[QP-1]};
        if (t >= {1'b0, d.w})
        begin
            r.rem = PT_W'(t - {1'b0, d.w});
            r.dq  = {d.dq[QP-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[PT_W-1:0];
            r.dq  = {d.dq[QP-2:0], 1'b0};
        end
        return r;
    endfunction

    // top bits start as remainder; they are below the width by construction
    always_comb
    begin
        div_init.rem  = prod.mag[MW-1:QP];
        div_init.dq   = prod.mag[QP-1:0];
        div_init.w    = prod.w;
        div_init.base = prod.base;
        div_init.neg  = prod.neg;
        div_init.ok   = prod.ok;
    end

    always_comb
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            div_next[k] = (k == 0) ? div_init : div_reg[(k == 0) ? 0 : k - 1];
            for (int s = 0; s < DIV_STEPS; s++)
                div_next[k] = div_step(div_next[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (en[k])
                div_reg[k] <= div_next[k];
        end
    end

    assign quot = div_reg[DIV_STAGES-1];

endmodule

// ===== rtl/core/fppi_back.sv =====
// ---------------------------------------------------------------------------
// Polyline interpolator back end
// Apply sign, add scaled base value, saturate to the output width.
// ---------------------------------------------------------------------------
module fppi_back
    import fppi_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  div_t                  quot,
    output logic signed [Y_W-1:0] y_percent,
    output logic                  curve_ok
);

    localparam logic signed [YW-1:0] SAT_HI = YW'(2 ** (Y_W - 1) - 1);
    localparam logic signed [YW-1:0] SAT_LO = -YW'(2 ** (Y_W - 1));

    logic signed [YW-1:0]  base_s;
    logic signed [YW-1:0]  q_s;
    logic signed [YW-1:0]  sum;
    logic signed [Y_W-1:0] y_next;
    logic signed [Y_W-1:0] y_reg;
    logic                  ok_reg;

    always_comb
    begin
        base_s = YW'(quot.base) <<< FRAC_BITS;
        q_s    = $signed(YW'(quot.dq));
        sum    = quot.neg ? (base_s - q_s) : (base_s + q_s);
        priority if (sum > SAT_HI)
            y_next = SAT_HI[Y_W-1:0];
        else if (sum < SAT_LO)
            y_next = SAT_LO[Y_W-1:0];
        else
            y_next = sum[Y_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg  <= y_next;
            ok_reg <= quot.ok;
        end
    end

    assign y_percent = y_reg;
    assign curve_ok  = ok_reg;

endmodule

// ===== rtl/core/four_point_polyline_interpolator_unit.sv =====
// Words pass through NUM_STAGES registered stages: select, multiply, divide stages, sum.
// Throughput: one word per cycle while the output is not stalled; depth is set by
// the divider, two quotient bits per stage over the segment-width division.
// A stalled output still accepts input while any pipeline stage is empty.
// Reset clears all valid bits and loads the default breakpoints.
// ---------------------------------------------------------------------------
// Four-point polyline interpolator
// Piecewise-linear curve over four programmable breakpoints, pipelined.
// ---------------------------------------------------------------------------
module four_point_polyline_interpolator_unit
    import fppi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,   // [16:0] x_percent, [23:17] zero
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [15:0] y_percent
    output logic [0:0]       m_tuser,   // [0] curve_ok
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [PT_W-1:0]  cfg_wdata
);

    logic [NUM_PTS-1:0][PT_W-1:0] x_pt_reg;
    logic [NUM_PTS-1:0][PT_W-1:0] x_pt_next;
    logic [NUM_PTS-1:0][PT_W-1:0] y_pt_reg;
    logic [NUM_PTS-1:0][PT_W-1:0] y_pt_next;
    logic [NUM_STAGES-1:0]        valid_reg;
    logic [NUM_STAGES-1:0]        valid_next;
    logic [NUM_STAGES-1:0]        load;
    cfg_t                         cfg;
    prod_t                        prod;
    div_t                         quot;
    logic signed [Y_W-1:0]        y_out;
    logic                         ok_out;

    always_comb
    begin
        x_pt_next = x_pt_reg;
        y_pt_next = y_pt_reg;
        if (cfg_we)
        begin
            if (cfg_index < CFG_Y_POINT_0)
                x_pt_next[cfg_index[1:0] - CFG_X_POINT_0[1:0]] = cfg_wdata;
            else
                y_pt_next[cfg_index[1:0]] = cfg_wdata;
        end
    end

    // a stage loads when it or a later stage has a hole, or the output drains
    genvar gi;
    generate
        for (gi = 0; gi < NUM_STAGES; gi++)
        begin : g_load
            assign load[gi] = m_tready || !(&valid_reg[NUM_STAGES-1:gi]);
        end
    endgenerate

    always_comb
    begin
        valid_next[0] = load[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pt_reg  <= X_PT_RESET;
            y_pt_reg  <= Y_PT_RESET;
            valid_reg <= '0;
        end
        else
        begin
            x_pt_reg  <= x_pt_next;
            y_pt_reg  <= y_pt_next;
            valid_reg <= valid_next;
        end
    end

    assign cfg.x_pt = x_pt_reg;
    assign cfg.y_pt = y_pt_reg;

    fppi_front u_front (
        .clk  (clk),
        .en   (load[1:0]),
        .x_in ($signed(s_tdata[X_W-1:0])),
        .cfg  (cfg),
        .prod (prod)
    );

    fppi_div u_div (
        .clk  (clk),
        .en   (load[DIV_STAGES+1:2]),
        .prod (prod),
        .quot (quot)
    );

    fppi_back u_back (
        .clk       (clk),
        .en        (load[NUM_STAGES-1]),
        .quot      (quot),
        .y_percent (y_out),
        .curve_ok  (ok_out)
    );

    assign s_tready   = load[0];
    assign m_tvalid   = valid_reg[NUM_STAGES-1];
    assign m_tdata    = y_out;
    assign m_tuser[0] = ok_out;

endmodule

// ===== rtl/core/fppi_checker.sv =====
// ---------------------------------------------------------------------------
// Polyline interpolator port checker
// Watches the stream ports of the interpolator over time.
// ---------------------------------------------------------------------------
`include "four_point_polyline_interpolator_unit_macros.svh"

module fppi_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // hold a stalled output word
    `FPPI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // a bad curve always reads zero
    `FPPI_ASSERT_IMPL(a_bad_curve_zero, m_tvalid && !m_tuser[0], m_tdata == 16'd0)
    // a draining or empty output never blocks the input
    `FPPI_ASSERT_IMPL(a_ready_when_drained, m_tready || !m_tvalid, s_tready)

endmodule

bind four_point_polyline_interpolator_unit fppi_checker u_fppi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/tb_four_point_polyline_interpolator_unit.sv =====
// ---------------------------------------------------------------------------
// Four-point polyline interpolator testbench
// Programs breakpoint sets, streams x queries with random gaps and back
// pressure, and scores each y word and curve_ok flag against a local model.
// ---------------------------------------------------------------------------
module tb_four_point_polyline_interpolator_unit;
    import fppi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TARGET_QUERIES = 1880;

    typedef struct packed {
        logic [Y_W-1:0] y;
        logic           ok;
    } curve_out_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [23:0]      s_tdata = '0;     // [16:0] x_percent, [23:17] zero
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [15:0]      m_tdata;          // [15:0] y_percent
    logic [0:0]       m_tuser;          // [0] curve_ok
    logic             cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [PT_W-1:0]  cfg_wdata = '0;

    // breakpoints as currently programmed
    logic [PT_W-1:0]        bp_x [NUM_PTS];
    logic signed [PT_W-1:0] bp_y [NUM_PTS];

    logic [X_W-1:0] x_pending [$];
    curve_out_t     curve_expected [$];

    bit  send_idle = 1'b0;
    bit  recv_idle = 1'b0;
    int  stall_req = 0;
    int  stall_seen = 0;
    int  send_gap = 0;
    int  hold_cnt = 0;
    int  roll = 0;
    int  recv_roll = 0;
    bit  ready_next = 1'b0;
    int  mismatch_count = 0;
    int  queries_sent = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    int  curves_loaded = 0;
    int  bad_curves = 0;
    curve_out_t next_due;

    four_point_polyline_interpolator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    function automatic bit curve_sorted();
        return bp_x[0] <= bp_x[1] && bp_x[1] <= bp_x[2] && bp_x[2] <= bp_x[3];
    endfunction

    function automatic curve_out_t curve_value(logic signed [X_W-1:0] xq);
        longint one;
        longint xv;
        longint yv;
        longint dxv;
        longint dyv;
        longint wv;
        longint xs [NUM_PTS];
        longint ys [NUM_PTS];
        int seg;
        curve_out_t r;
        one = longint'(1) << FRAC_BITS;
        xv = longint'(xq);
        for (int i = 0; i < NUM_PTS; i++)
        begin
            xs[i] = longint'(bp_x[i]);
            ys[i] = longint'(bp_y[i]);
        end
        r.ok = curve_sorted();
        if (!r.ok)
            yv = 0;
        else if (xv < xs[0] * one)
            yv = ys[0] * one;
        else if (xv >= xs[3] * one)
            yv = ys[3] * one;
        else
        begin
            seg = 0;
            if (xv >= xs[1] * one)
                seg = 1;
            if (xv >= xs[2] * one)
                seg = 2;
            dxv = xv - xs[seg] * one;
            dyv = ys[seg + 1] - ys[seg];
            wv = xs[seg + 1] - xs[seg];
            // quotient truncates toward zero
            yv = ys[seg] * one + (dxv * dyv) / wv;
        end
        if (yv > 32767)
            yv = 32767;
        if (yv < -32768)
            yv = -32768;
        r.y = yv[Y_W-1:0];
        return r;
    endfunction

    // mostly inside the curve span, some near breakpoints, rest anywhere
    function automatic logic [X_W-1:0] pick_query();
        int one;
        int r;
        int k;
        int lo;
        int hi;
        one = 1 << FRAC_BITS;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            k = $urandom_range(0, NUM_PTS - 1);
            lo = int'(bp_x[k]) * one + int'($urandom_range(0, 6)) - 3;
            return X_W'(lo);
        end
        if (r < 85 && curve_sorted())
        begin
            lo = int'(bp_x[0]) * one - one;
            hi = int'(bp_x[3]) * one + one;
            return X_W'(lo + int'($urandom_range(0, hi - lo)));
        end
        return X_W'($urandom);
    endfunction

    task automatic flag_mismatch(string msg);
        if (mismatch_count < 10)
            $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatch_count++;
    endtask

    // ---------------- sender ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                curve_expected.push_back(curve_value(s_tdata[X_W-1:0]));
                queries_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (x_pending.size() > 0)
                begin
                    s_tdata <= {7'b0, x_pending.pop_front()};
                    s_tvalid <= 1'b1;
                    if (send_idle)
                    begin
                        roll = $urandom_range(0, 99);
                        if (roll >= 92)
                            send_gap = $urandom_range(8, 40);
                        else if (roll >= 60)
                            send_gap = $urandom_range(1, 3);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- receiver and scoreboard ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (curve_expected.size() == 0)
                    flag_mismatch($sformatf("unexpected word y=%0d ok=%0b",
                                            $signed(m_tdata), m_tuser[0]));
                else
                begin
                    next_due = curve_expected.pop_front();
                    if (m_tdata !== next_due.y || m_tuser[0] !== next_due.ok)
                        flag_mismatch($sformatf("y exp %0d got %0d, ok exp %0b got %0b",
                                                $signed(next_due.y), $signed(m_tdata),
                                                next_due.ok, m_tuser[0]));
                    results_seen++;
                end
            end
            // long hold-off on request, so the pipeline fills and backs up
            if (stall_req != stall_seen)
            begin
                stall_seen = stall_req;
                hold_cnt = 300;
            end
            ready_next = 1'b1;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                ready_next = 1'b0;
            end
            else if (recv_idle)
            begin
                recv_roll = $urandom_range(0, 99);
                if (recv_roll < 3)
                begin
                    hold_cnt = $urandom_range(8, 40);
                    ready_next = 1'b0;
                end
                else if (recv_roll < 30)
                    ready_next = 1'b0;
            end
            m_tready <= ready_next;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, curve_expected.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic wait_drained();
        do
            @(negedge clk);
        while (x_pending.size() != 0 || s_tvalid || curve_expected.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_curve(input logic [PT_W-1:0] x0, x1, x2, x3,
                             input logic [PT_W-1:0] y0, y1, y2, y3);
        logic [PT_W-1:0] vals [2*NUM_PTS];
        vals = '{x0, x1, x2, x3, y0, y1, y2, y3};
        for (int i = 0; i < NUM_PTS; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= CFG_X_POINT_0 + IDX_W'(i);
            cfg_wdata <= vals[i];
            bp_x[i] = vals[i];
        end
        for (int i = 0; i < NUM_PTS; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= CFG_Y_POINT_0 + IDX_W'(i);
            cfg_wdata <= vals[NUM_PTS + i];
            bp_y[i] = vals[NUM_PTS + i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        curves_loaded++;
        if (!curve_sorted())
            bad_curves++;
        @(negedge clk);
    endtask

    task automatic random_curve();
        logic [PT_W-1:0] xs [NUM_PTS];
        logic [PT_W-1:0] ys [NUM_PTS];
        logic [PT_W-1:0] t;
        int kind;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < NUM_PTS; i++)
        begin
            xs[i] = PT_W'($urandom);
            ys[i] = PT_W'($urandom);
            if (kind >= 90)
            begin
                xs[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                ys[i] = $urandom_range(0, 1) ? 8'h7f : 8'h80;
            end
        end
        if (kind < 80 || kind >= 90)
        begin
            // bubble into ascending order
            for (int p = 0; p < NUM_PTS - 1; p++)
                for (int i = 0; i < NUM_PTS - 1 - p; i++)
                    if (xs[i] > xs[i + 1])
                    begin
                        t = xs[i];
                        xs[i] = xs[i + 1];
                        xs[i + 1] = t;
                    end
            // collapse one segment to zero width
            if (kind >= 70 && kind < 80)
            begin
                t = PT_W'($urandom_range(0, 2));
                xs[t + 1] = xs[t];
            end
        end
        set_curve(xs[0], xs[1], xs[2], xs[3], ys[0], ys[1], ys[2], ys[3]);
    endtask

    initial
    begin
        int n;
        int total;
        int rounds;
        bp_x = '{8'd0, 8'd33, 8'd66, 8'd100};
        bp_y = '{8'sd0, 8'sd33, 8'sd66, 8'sd100};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset curve: field extremes, clamps, every segment, breakpoint edges
        x_pending = '{17'h10000, 17'h1ffff, 17'h00000, 17'h00001, 17'd8447, 17'd8448,
                      17'd12877, 17'd25599, 17'd25600, 17'h0ffff, 17'h15555, 17'h0aaaa};
        wait_drained();

        // full scale y, outer segments of zero width
        set_curve(8'd0, 8'd0, 8'd255, 8'd255, 8'h80, 8'h7f, 8'h80, 8'h7f);
        x_pending = '{17'd0, 17'd65279, 17'd65280, 17'd32640, 17'h1ffff};
        wait_drained();

        // middle segment of zero width
        set_curve(8'd0, 8'd10, 8'd10, 8'd255, 8'h7f, 8'h80, 8'h7f, 8'h80);
        x_pending = '{17'd2560, 17'd2559, 17'd1283};
        wait_drained();

        // breakpoints out of order
        set_curve(8'd100, 8'd50, 8'd150, 8'd200, 8'd10, 8'd20, 8'd30, 8'd40);
        x_pending = '{17'd0, 17'd30720, 17'h0ffff};
        wait_drained();

        total = 0;
        rounds = 0;
        while (total < TARGET_QUERIES)
        begin
            wait_drained();
            random_curve();
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            if (rounds == 2)
            begin
                // back-to-back words against a long hold-off
                send_idle = 1'b0;
                recv_idle = 1'b0;
                stall_req++;
                n = 80;
            end
            else
                n = $urandom_range(30, 110);
            repeat (n) x_pending.push_back(pick_query());
            total += n;
            rounds++;
        end

        wait_drained();
        repeat (NUM_STAGES + 8) @(posedge clk);
        if (curve_expected.size() != 0)
            flag_mismatch($sformatf("%0d words never arrived", curve_expected.size()));
        $display("%0d queries over %0d breakpoint sets (%0d out of order), %0d words checked",
                 queries_sent, curves_loaded, bad_curves, results_seen);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== four_point_polyline_interpolator_unit.f =====
+incdir+rtl/core
rtl/core/fppi_pkg.sv
rtl/core/fppi_front.sv
rtl/core/fppi_div.sv
rtl/core/fppi_back.sv
rtl/core/four_point_polyline_interpolator_unit.sv
rtl/core/fppi_checker.sv
test/tb_four_point_polyline_interpolator_unit.sv
